// File: hdl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

  localparam int unsigned FRAME_BYTES_DEFAULT = 16;

  localparam logic [7:0] HEAD_MARK = 8'hA5;
  localparam logic [7:0] TAIL_MARK = 8'h5A;

  localparam int unsigned CAPTURE_DEPTH = 13;
  localparam int unsigned FLAG_COUNT = 5;
  // first capture entry of each little-endian word
  localparam int unsigned ANGLE_BASE = 5;
  localparam int unsigned SPEED_BASE = 9;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic               ok;
    byte_t [FLAG_COUNT-1:0] flags;
    logic signed [31:0] angle;
    logic signed [31:0] speed;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/cfr_track.sv
`default_nettype none
module cfr_track #(
  parameter int unsigned FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEFAULT,
  parameter int unsigned POS_W = $clog2(FRAME_BYTES)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire cfr_pkg::byte_t  data,
  output logic [POS_W-1:0]     pos,
  output logic                 last,
  output cfr_pkg::result_t     result
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CSUM_POS = POS_W'(FRAME_BYTES - 2);

  logic [7:0] running_sum;
  logic       header_seen;
  logic       checksum_ok;
  cfr_pkg::byte_t capture [cfr_pkg::CAPTURE_DEPTH];
  cfr_pkg::byte_t [cfr_pkg::FLAG_COUNT-1:0] held_flags;
  logic signed [31:0] held_angle;
  logic signed [31:0] held_speed;

  logic ok;
  logic is_first;
  logic is_payload;
  logic is_csum;

  assign last       = (pos == LAST_POS);
  assign is_first   = (pos == '0);
  assign is_csum    = (pos == CSUM_POS);
  assign is_payload = !is_first && (pos < CSUM_POS);
  assign ok         = header_seen && checksum_ok && (data == cfr_pkg::TAIL_MARK);

  // result carries the held values as they stand after this byte
  always_comb begin
    result.ok    = ok;
    result.flags = held_flags;
    result.angle = held_angle;
    result.speed = held_speed;
    if (ok) begin
      for (int i = 0; i < cfr_pkg::FLAG_COUNT; i++) begin
        result.flags[i] = capture[i];
      end
      result.angle = {capture[cfr_pkg::ANGLE_BASE+3], capture[cfr_pkg::ANGLE_BASE+2],
                      capture[cfr_pkg::ANGLE_BASE+1], capture[cfr_pkg::ANGLE_BASE]};
      result.speed = {capture[cfr_pkg::SPEED_BASE+3], capture[cfr_pkg::SPEED_BASE+2],
                      capture[cfr_pkg::SPEED_BASE+1], capture[cfr_pkg::SPEED_BASE]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= '0;
      header_seen <= 1'b0;
      checksum_ok <= 1'b0;
      held_flags  <= '0;
      held_angle  <= '0;
      held_speed  <= '0;
    end else if (advance) begin
      if (last) begin
        pos        <= '0;
        held_flags <= result.flags;
        held_angle <= result.angle;
        held_speed <= result.speed;
      end else begin
        pos <= pos + 1'b1;
      end
      if (is_first) begin
        header_seen <= (data == cfr_pkg::HEAD_MARK);
        running_sum <= '0;
      end
      if (is_payload) begin
        running_sum <= running_sum + data;
      end
      if (is_csum) begin
        checksum_ok <= (running_sum == data);
      end
    end
  end

  // capture store, bytes 1 through 13 of the block
  for (genvar g = 0; g < cfr_pkg::CAPTURE_DEPTH; g++) begin : g_cap
    always_ff @(posedge clk) begin
      if (advance && (pos == POS_W'(g + 1))) begin
        capture[g] <= data;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/cfr_out.sv
`default_nettype none
module cfr_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cfr_pkg::result_t result,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  busy,
  output cfr_pkg::result_t      held
);

  // register is blocked when full and not being taken
  assign busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule
`default_nettype wire

// File: hdl/control_frame_receiver.sv
`default_nettype none
// control frame receiver: takes received serial bytes, one per transfer, and
// counts them into fixed blocks of FRAME_BYTES bytes. a block passes when
// byte 0 is 0xA5, the last byte is 0x5A and the 8-bit sum of the payload
// bytes matches the byte before the tail. every block's last byte yields one
// result transfer with frame_ok and the flags, angle and speed of the last
// block that passed (all zero until the first). blocks are counted purely by
// position: there is no hunt for the header, so a dropped byte shifts every
// later block. each byte passes through an input register and the
// frame logic, giving one byte per clock sustained; a result waits in the
// output register while later bytes keep coming, and the input stalls only
// when a block completes while the previous result has not been taken.
module control_frame_receiver #(
  parameter int unsigned FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [7:0]       radar_on,
  output logic [7:0]       dir_forward,
  output logic [7:0]       dir_back,
  output logic [7:0]       turn_left,
  output logic [7:0]       turn_right,
  output logic signed [31:0] angle_word,
  output logic signed [31:0] speed_word
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  // input register
  logic           byte_valid;
  cfr_pkg::byte_t byte_q;

  logic             advance;
  logic             last;
  logic             out_busy;
  logic [POS_W-1:0] pos;
  cfr_pkg::result_t result;
  cfr_pkg::result_t held;

  // a byte moves on unless it closes a block while the result slot is full and not being taken
  assign advance  = byte_valid && !(last && out_busy);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  // position counter, checksum, capture and held values
  cfr_track #(
    .FRAME_BYTES(FRAME_BYTES),
    .POS_W      (POS_W)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .data   (byte_q),
    .pos    (pos),
    .last   (last),
    .result (result)
  );

  // result register
  cfr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && last),
    .result   (result),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .busy     (out_busy),
    .held     (held)
  );

  assign frame_ok     = held.ok;
  assign radar_on     = held.flags[0];
  assign dir_forward  = held.flags[1];
  assign dir_back     = held.flags[2];
  assign turn_left    = held.flags[3];
  assign turn_right   = held.flags[4];
  assign angle_word   = held.angle;
  assign speed_word   = held.speed;

  // position never runs past the end of a block
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(FRAME_BYTES - 1))
    else $error("byte position out of range");

  // a finished block never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(advance && last && out_valid && !out_ready))
    else $error("result overwritten");

  // the closing byte of a block always produces a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> out_valid && pos == '0)
    else $error("missing result after block end");

  // inside a block the position steps by one per byte
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    advance && !last |=> pos == $past(pos) + 1'b1)
    else $error("byte position skipped");

endmodule
`default_nettype wire
